@@ rtl/core/float_narrow_round_nearest_even_assert.svh @@
// Assertion macros for the narrowing rounding unit.
// Used by the checker module; no other dependencies.
`ifndef FLOAT_NARROW_ROUND_NEAREST_EVEN_ASSERT_SVH
`define FLOAT_NARROW_ROUND_NEAREST_EVEN_ASSERT_SVH

// Same-cycle implication, masked during reset.
`define FNR_ASSERT_NOW(lbl, clk, rst, a, c) \
  lbl: assert property (@(posedge clk) disable iff (rst) (a) |-> (c)) \
    else $error("assertion failed");

// Next-cycle implication, masked during reset.
`define FNR_ASSERT_NEXT(lbl, clk, rst, a, c) \
  lbl: assert property (@(posedge clk) disable iff (rst) (a) |=> (c)) \
    else $error("assertion failed");

// Next-cycle implication, live through reset.
`define FNR_ASSERT_RST(lbl, clk, a, c) \
  lbl: assert property (@(posedge clk) (a) |=> (c)) \
    else $error("assertion failed");

`endif

@@ rtl/core/fnr_pkg.sv @@
// Package for the narrowing rounding unit: format constants.
// No dependencies.
`timescale 1ns / 1ps
package fnr_pkg;
  localparam int unsigned DataW = 64;
  localparam logic [10:0] ExpAllOnes = 11'h7FF;
  // Below these biased exponents the target's subnormal quantum applies.
  localparam logic [10:0] SubThrSingle = 11'd897;
  localparam logic [10:0] SubThrHalf   = 11'd1009;
  // At or below these the value is under half a quantum.
  localparam logic [10:0] ZeroMaxSingle = 11'd872;
  localparam logic [10:0] ZeroMaxHalf   = 11'd997;
  // Shift bases in the subnormal range (qmin + 1075).
  localparam logic [10:0] ShiftBaseSingle = 11'd926;
  localparam logic [10:0] ShiftBaseHalf   = 11'd1051;
  // Normal-range discard counts (53 - precision).
  localparam logic [5:0] ShiftNormSingle = 6'd29;
  localparam logic [5:0] ShiftNormHalf   = 6'd42;
  // Largest finite biased exponent (emax + 1023).
  localparam logic [11:0] ExpMaxSingle = 12'd1150;
  localparam logic [11:0] ExpMaxHalf   = 12'd1038;
  localparam logic CmdSingle = 1'b0;
  localparam logic CmdHalf   = 1'b1;
endpackage

@@ rtl/core/fnr_round.sv @@
// Combinational rounding datapath: binary64 to binary32/binary16 precision.
// Depends on fnr_pkg.
`timescale 1ns / 1ps
module fnr_round import fnr_pkg::*; (
  input  logic             cmd,
  input  logic [DataW-1:0] value_bits,
  output logic [DataW-1:0] result_bits
);
  logic        sign;
  logic [10:0] bexp;
  logic [53:0] m;
  logic        half;
  logic        sub;
  logic        to_zero;
  logic [10:0] sub_shift;
  logic [5:0]  shift;
  logic [53:0] keep_mask;
  logic [53:0] sticky_mask;
  logic        rbit;
  logic        lsb;
  logic        sticky;
  logic        inc;
  logic [53:0] r;
  logic [11:0] e_out;
  logic [51:0] frac_out;

  always_comb begin
    sign = value_bits[63];
    bexp = value_bits[62:52];
    m    = {2'b01, value_bits[51:0]};
    half = (cmd == CmdHalf);
    sub  = half ? (bexp < SubThrHalf) : (bexp < SubThrSingle);
    to_zero = half ? (bexp <= ZeroMaxHalf) : (bexp <= ZeroMaxSingle);
    sub_shift = (half ? ShiftBaseHalf : ShiftBaseSingle) - bexp;
    if (sub) shift = sub_shift[5:0];
    else shift = half ? ShiftNormHalf : ShiftNormSingle;
    keep_mask   = ~((54'd1 << shift) - 54'd1);
    sticky_mask = (54'd1 << (shift - 6'd1)) - 54'd1;
    rbit   = m[shift - 6'd1];
    lsb    = m[shift];
    sticky = |(m & sticky_mask);
    inc    = rbit & (sticky | lsb);
    r      = (m & keep_mask) + (inc ? (54'd1 << shift) : 54'd0);
    if (r[53]) begin
      e_out    = {1'b0, bexp} + 12'd1;
      frac_out = r[52:1];
    end else begin
      e_out    = {1'b0, bexp};
      frac_out = r[51:0];
    end

    if (bexp == ExpAllOnes) result_bits = value_bits;
    else if (bexp == 11'd0) begin
      result_bits = (value_bits[51:0] == 52'd0) ? value_bits : {sign, 63'd0};
    end else if (to_zero || r == 54'd0) result_bits = {sign, 63'd0};
    else if (e_out > (half ? ExpMaxHalf : ExpMaxSingle)) begin
      result_bits = {sign, ExpAllOnes, 52'd0};
    end else result_bits = {sign, e_out[10:0], frac_out};
  end
endmodule

@@ rtl/core/float_narrow_round_nearest_even.sv @@
// Top level of the narrowing rounding unit: input register, rounding
// datapath, result register. Depends on fnr_pkg and fnr_round.
`timescale 1ns / 1ps
// Rounds a binary64 word to the nearest binary32 (cmd 0) or binary16
// (cmd 1) value, ties to even, subnormal quanta included, and returns it
// re-encoded as binary64. NaN, infinities and signed zeros pass unchanged;
// overflow gives a signed infinity and underflow a signed zero. One word
// is taken every cycle while the result register is free or being
// emptied; each word passes the input register, the single-pass rounding
// logic and the result register, and is offered from the result register.
// A stalled result holds both registers once both are full.
module float_narrow_round_nearest_even import fnr_pkg::*; (
  input  logic             clk,
  input  logic             rst,
  input  logic             in_valid,
  output logic             in_ready,
  input  logic             cmd,
  input  logic [DataW-1:0] value_bits,
  output logic             out_valid,
  input  logic             out_ready,
  output logic [DataW-1:0] result_bits
);
  logic             s1_valid;
  logic             s1_cmd;
  logic [DataW-1:0] s1_bits;
  logic [DataW-1:0] rounded;
  logic             advance;

  // Advance whenever the result register is free or being emptied.
  assign advance  = !out_valid || out_ready;
  assign in_ready = !s1_valid || advance;

  // Capture the incoming word.
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (in_ready) begin
      s1_valid <= in_valid;
    end
    if (in_ready && in_valid) begin
      s1_cmd  <= cmd;
      s1_bits <= value_bits;
    end
  end

  fnr_round u_round (
    .cmd         (s1_cmd),
    .value_bits  (s1_bits),
    .result_bits (rounded)
  );

  // Hold the result until taken.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (advance) begin
      out_valid <= s1_valid;
    end
    if (advance && s1_valid) begin
      result_bits <= rounded;
    end
  end
endmodule

@@ rtl/core/fnr_checker.sv @@
// Port-level checker for the narrowing rounding unit, bound to the top.
// Depends on fnr_pkg and the assertion macro header.
`timescale 1ns / 1ps
`include "float_narrow_round_nearest_even_assert.svh"
module fnr_checker import fnr_pkg::*; (
  input logic             clk,
  input logic             rst,
  input logic             in_ready,
  input logic             out_valid,
  input logic             out_ready,
  input logic [DataW-1:0] result_bits
);
  `FNR_ASSERT_RST(a_reset_empty, clk, rst, !out_valid)
  `FNR_ASSERT_NOW(a_ready_when_empty, clk, rst, !out_valid, in_ready)
  `FNR_ASSERT_NEXT(a_stall_holds, clk, rst, out_valid && !out_ready, out_valid && $stable(result_bits))
endmodule

bind float_narrow_round_nearest_even fnr_checker u_fnr_checker (
  .clk         (clk),
  .rst         (rst),
  .in_ready    (in_ready),
  .out_valid   (out_valid),
  .out_ready   (out_ready),
  .result_bits (result_bits)
);

@@ bench/fnr_checker.sv @@
// Checker for the narrowing rounding unit: watches both channels, predicts
// each result from the accepted word and compares. Depends on fnr_pkg.
`timescale 1ns / 1ps
module tb_fnr_checker import fnr_pkg::*; (
  input  logic             clk,
  input  logic             rst,
  input  logic             in_valid,
  input  logic             in_ready,
  input  logic             cmd,
  input  logic [DataW-1:0] value_bits,
  input  logic             out_valid,
  input  logic             out_ready,
  input  logic [DataW-1:0] result_bits,
  output int               fail_count,
  output int               pending
);
  logic [DataW-1:0] rounded_q[$];

  function automatic logic [63:0] narrow_value(input logic to_half, input logic [63:0] x);
    logic [63:0] sgn, m, lower, rem, hw, rnd;
    logic [10:0] bexp;
    int prec, qmin, emax, ex, quantum, shift, len, vexp;
    sgn = {x[63], 63'd0};
    bexp = x[62:52];
    prec = to_half ? 11 : 24;
    qmin = to_half ? -24 : -149;
    emax = to_half ? 15 : 127;
    if (bexp == ExpAllOnes) return x;
    if (bexp == 11'd0) return (x[51:0] == 0) ? x : sgn;
    m = {11'd1, x[51:0]};
    ex = int'(bexp) - 1022;
    quantum = ex - prec;
    if (quantum < qmin) quantum = qmin;
    shift = quantum - (int'(bexp) - 1075);
    if (shift >= 54) return sgn;
    lower = m >> shift;
    rem = m & ((64'd1 << shift) - 64'd1);
    hw = 64'd1 << (shift - 1);
    rnd = lower;
    if (rem > hw || (rem == hw && lower[0])) rnd = rnd + 64'd1;
    if (rnd == 0) return sgn;
    len = 0;
    for (int i = 0; i < 64; i++) if (rnd[i]) len = i + 1;
    vexp = quantum + len - 1;
    if (vexp > emax) return sgn | {1'b0, ExpAllOnes, 52'd0};
    return sgn | (64'(vexp + 1023) << 52) | ((rnd << (53 - len)) & 64'hF_FFFF_FFFF_FFFF);
  endfunction

  assign pending = rounded_q.size();

  always @(posedge clk) begin
    if (rst) begin
      fail_count <= 0;
    end else begin
      if (in_valid && in_ready) rounded_q.push_back(narrow_value(cmd, value_bits));
      if (out_valid && out_ready) begin
        if (rounded_q.size() == 0) begin
          $error("result_bits: no word expected, got %h", result_bits);
          fail_count <= fail_count + 1;
        end else if (rounded_q[0] !== result_bits) begin
          $error("result_bits: expected %h, got %h", rounded_q[0], result_bits);
          fail_count <= fail_count + 1;
          void'(rounded_q.pop_front());
        end else begin
          void'(rounded_q.pop_front());
        end
      end
    end
  end
endmodule

@@ bench/tb_float_narrow_round_nearest_even.sv @@
// Testbench top for the narrowing rounding unit: drives operand words under
// several idling phases and gives the verdict. Depends on the unit, fnr_pkg, tb_fnr_checker.
`timescale 1ns / 1ps
module tb_float_narrow_round_nearest_even import fnr_pkg::*;;
  logic             clk = 1'b0;
  logic             rst = 1'b1;
  logic             in_valid = 1'b0;
  logic             in_ready;
  logic             cmd = CmdSingle;
  logic [DataW-1:0] value_bits = '0;
  logic             out_valid;
  logic             out_ready = 1'b0;
  logic [DataW-1:0] result_bits;
  int               fail_count, pending;
  int               send_idle_pct = 0, recv_stall_pct = 0;
  int               stall_cycles = 0;
  localparam int    StallLimit = 4000;

  always #4 clk = ~clk;

  float_narrow_round_nearest_even i_dut (.*);

  tb_fnr_checker i_checker (.*);

  // Receiver: stall at random per the current phase.
  always @(posedge clk)
    out_ready <= ($urandom_range(99) >= recv_stall_pct);

  // Watchdog: count cycles with no word moving on either channel.
  always @(posedge clk) begin
    if (rst || (in_valid && in_ready) || (out_valid && out_ready)) stall_cycles <= 0;
    else stall_cycles <= stall_cycles + 1;
    if (stall_cycles >= StallLimit) begin
      $display("Some tests failed");
      $finish;
    end
  end

  // Present one word, hold it until accepted, optionally idle first.
  task automatic send_word(input logic c, input logic [63:0] v);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid   <= 1'b1;
    cmd        <= c;
    value_bits <= v;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
  endtask

  task automatic drain_results();
    in_valid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
  endtask

  // Random operand biased to exponents around each format's edges.
  function automatic logic [63:0] pick_value(input logic c);
    logic [63:0] v;
    int e, base;
    v = {$urandom, $urandom};
    base = (c == CmdHalf) ? 1009 : 897;
    case ($urandom_range(9))
      0, 1, 2: e = base - 26 + $urandom_range(30);
      3, 4:    e = ((c == CmdHalf) ? 1038 : 1150) - 2 + $urandom_range(4);
      5:       e = $urandom_range(1) ? 0 : 2047;
      6:       e = 1023 - 4 + $urandom_range(8);
      default: e = int'(v[62:52]);
    endcase
    v[62:52] = 11'(e);
    // Force ties and near-ties in the discarded bits now and then.
    if ($urandom_range(3) == 0) v[40:0] = $urandom_range(1) ? 41'd0 : {1'b1, 40'd0};
    return v;
  endfunction

  initial begin
    logic [63:0] edge_words[$];
    logic c;
    edge_words = {64'h0000_0000_0000_0000, 64'h8000_0000_0000_0000,
                  64'h7FF0_0000_0000_0000, 64'hFFF0_0000_0000_0000,
                  64'h7FF8_0000_0000_1234, 64'hFFF0_0000_0000_0001,
                  64'h0000_0000_0000_0001, 64'h800F_FFFF_FFFF_FFFF,
                  64'h3FF0_0000_1000_0000, 64'h3FF0_0000_3000_0000,
                  64'h47EF_FFFF_F000_0000, 64'hC7EF_FFFF_EFFF_FFFF,
                  64'h40EF_FE00_0000_0000, 64'h40EF_FF00_0000_0000,
                  64'h3E70_0000_0000_0000, 64'h3E80_0000_0000_0001,
                  64'h36A0_0000_0000_0000, 64'h36A0_0000_0000_0001,
                  64'h7FEF_FFFF_FFFF_FFFF, 64'h3FF5_5555_5555_5555,
                  64'hFFFF_FFFF_FFFF_FFFF, 64'h0010_0000_0000_0000};
    repeat (10) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    // Directed: every edge word in both formats.
    foreach (edge_words[i]) begin
      send_word(CmdSingle, edge_words[i]);
      send_word(CmdHalf, edge_words[i]);
    end
    // Hold off until every result is home, then run the idling phases.
    drain_results();
    for (int ph = 0; ph < 5; ph++) begin
      case (ph)
        0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
        1: begin send_idle_pct = 81; recv_stall_pct = 0;  end
        2: begin send_idle_pct = 0;  recv_stall_pct = 81; end
        3: begin send_idle_pct = 14; recv_stall_pct = 14; end
        default: begin send_idle_pct = 0; recv_stall_pct = 0; end
      endcase
      for (int n = 0; n < 350; n++) begin
        c = 1'($urandom_range(1));
        send_word(c, pick_value(c));
      end
    end
    drain_results();
    repeat (10) @(posedge clk);
    if (fail_count == 0) $display("All tests passed");
    else $display("Some tests failed");
    $finish;
  end
endmodule
